[rtl/mbp_pkg.sv]
package mbp_pkg;

   // widths fixed by the field definitions
   localparam int VALUE_W   = 32;
   localparam int LEN_W     = 6;
   localparam int TOTAL_W   = 31;
   localparam int PART_W    = 7;
   localparam int FILL_W    = 3;
   localparam int ACC_W     = PART_W + VALUE_W;
   localparam int WORD_W    = ACC_W + 1;
   localparam int MAX_BYTES = 4;
   localparam int CNT_W     = 3;

   // running total limit
   localparam int COUNT_BITS = 31;
   localparam logic [31:0] MAX_TOTAL = 32'((64'd1 << COUNT_BITS) - 64'd1);

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_NONE  = 2'd1,
      KIND_RANGE = 2'd2,
      KIND_LONG  = 2'd3
   } kind_type;

   typedef enum logic {
      MODE_APPEND = 1'b0,
      MODE_FINISH = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [VALUE_W-1:0]   value;
      logic [LEN_W-1:0]     bit_len;
   } req_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      kind_type             kind;
      logic                 last_of_run;
      logic [TOTAL_W-1:0]   bits_total;
   } rsp_type;

   // one classified request: the results it causes
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      kind_type                  kind;
      logic [TOTAL_W-1:0]        total;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } qstat_type;

endpackage

[rtl/msb_first_bit_packer.sv]
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  req_data  (mode, value, bit_len)
// rsp_      out        rsp_valid / rsp_ready  rsp_data  (out_byte, kind, last_of_run, bits_total)
//
// a request is checked and the packer state updated in the cycle it is accepted
// each request gives max(1, bytes completed) results, one per cycle while rsp_ready is high, set by the output register
// the first result of a request is written into the queue, then loaded into the output register
// synchronous reset clears packer state, the two-entry queue and the output valid
// with rsp_ready low the output holds; req_ready drops once the queue holds two requests
module msb_first_bit_packer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mbp_pkg::rsp_type rsp_data
);
   import mbp_pkg::*;

   job_type   push_job;
   job_type   head;
   qstat_type stat;
   logic      push;
   logic      pop;

   assign req_ready = stat.not_full;
   assign push      = req_valid && stat.not_full;

   // classify requests and track packer state
   mbp_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_data),
      .push  (push),
      .job   (push_job)
   );

   // decoupling queue
   mbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .stat     (stat)
   );

   // result sequencing
   mbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (stat.not_empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[rtl/mbp_front.sv]
module mbp_front (
   input  logic             clock,
   input  logic             reset,
   input  mbp_pkg::req_type req,
   input  logic             push,
   output mbp_pkg::job_type job
);
   import mbp_pkg::*;

   logic [PART_W-1:0]  partial_ff, partial_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               range_err;
   logic               long_err;
   logic [31:0]        sum;
   logic [ACC_W-1:0]   acc;
   logic [LEN_W-1:0]   nbits;
   logic [WORD_W-1:0]  word;
   logic [7:0]         fin_byte;
   logic [7:0]         pmask;

   // checks and bit joining
   always_comb begin
      range_err = (req.bit_len > LEN_W'(32)) ||
                  ((req.bit_len < LEN_W'(32)) && ((req.value >> req.bit_len) != '0));
      sum       = 32'(total_ff) + 32'(req.bit_len);
      long_err  = sum > MAX_TOTAL;
      acc       = (ACC_W'(partial_ff) << req.bit_len) | ACC_W'(req.value);
      nbits     = LEN_W'(fill_ff) + req.bit_len;
      word      = WORD_W'(acc) << (LEN_W'(WORD_W) - nbits);
      fin_byte  = 8'(partial_ff) << (4'd8 - {1'b0, fill_ff});
      pmask     = (8'd1 << nbits[2:0]) - 8'd1;
   end

   // job building and next state
   always_comb begin
      job        = '0;
      job.count  = CNT_W'(1);
      job.kind   = KIND_NONE;
      job.total  = total_ff;
      partial_in = partial_ff;
      fill_in    = fill_ff;
      total_in   = total_ff;
      if (req.mode == MODE_FINISH) begin
         if (fill_ff != '0) begin
            job.kind     = KIND_DATA;
            job.bytes[0] = fin_byte;
         end
         partial_in = '0;
         fill_in    = '0;
         total_in   = '0;
      end else if (range_err) begin
         job.kind = KIND_RANGE;
      end else if (long_err) begin
         job.kind = KIND_LONG;
      end else begin
         job.total  = sum[TOTAL_W-1:0];
         total_in   = sum[TOTAL_W-1:0];
         fill_in    = nbits[2:0];
         partial_in = acc[PART_W-1:0] & pmask[PART_W-1:0];
         if (nbits[5:3] != '0) begin
            job.kind  = KIND_DATA;
            job.count = nbits[5:3];
            for (int k = 0; k < MAX_BYTES; k++) begin
               job.bytes[k] = word[WORD_W-1-8*k -: 8];
            end
         end
      end
   end

   // packer state
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
         total_ff   <= '0;
      end else if (push) begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
         total_ff   <= total_in;
      end
   end

endmodule

[rtl/mbp_queue.sv]
module mbp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbp_pkg::job_type   push_job,
   input  logic               pop,
   output mbp_pkg::job_type   head,
   output mbp_pkg::qstat_type stat
);
   import mbp_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head           = slot_ff[rd_ptr_ff];
   assign stat.not_empty = count_ff != '0;
   assign stat.not_full  = count_ff != QCNT_W'(QUEUE_DEPTH);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> stat.not_full)
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a write");
`endif

endmodule

[rtl/mbp_back.sv]
module mbp_back (
   input  logic             clock,
   input  logic             reset,
   input  mbp_pkg::job_type head,
   input  logic             head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mbp_pkg::rsp_type rsp_data
);
   import mbp_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       out_free;
   logic       last;
   logic       load;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = out_free && head_valid;
   assign last      = {1'b0, idx_ff} == (head.count - 1'b1);
   assign pop       = load && last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next result from the queue head
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = head_valid;
      end
      if (load) begin
         rsp_in.out_byte    = head.bytes[idx_ff];
         rsp_in.kind        = head.kind;
         rsp_in.last_of_run = last;
         rsp_in.bits_total  = head.total;
         idx_in             = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> ({1'b0, idx_ff} < head.count))
      else $error("byte index beyond job");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == '0)
      else $error("byte index left mid job");
   a_only_data_multi: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.last_of_run) |-> rsp_ff.kind == KIND_DATA)
      else $error("non data result not last");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import mbp_pkg::*;

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int ITEMS_PER_PHASE = 65;
   localparam int NUM_PHASES      = 4;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // requests waiting to be driven and packer results still owed
   req_type req_backlog[$];
   rsp_type bytes_due[$];

   int unsigned req_sent_cnt  = 0;
   int unsigned req_taken_cnt = 0;
   int unsigned bad_cnt       = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned idle_pct      = 0;
   int unsigned stall_pct     = 0;

   // shadow packer state
   logic [PART_W-1:0]  part_bits = '0;
   logic [FILL_W-1:0]  fill_cnt  = '0;
   logic [TOTAL_W-1:0] run_total = '0;

   msb_first_bit_packer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic req_type make_req(mode_type m, logic [VALUE_W-1:0] v,
                                        logic [LEN_W-1:0] n);
      req_type r;
      r.mode    = m;
      r.value   = v;
      r.bit_len = n;
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [7:0] b, kind_type k, logic last,
                                        logic [TOTAL_W-1:0] t);
      rsp_type r;
      r.out_byte    = b;
      r.kind        = k;
      r.last_of_run = last;
      r.bits_total  = t;
      return r;
   endfunction

   // append to the tail of the request backlog
   function automatic void add_req(req_type r);
      req_backlog = {req_backlog, r};
   endfunction

   // append to the tail of the owed results
   function automatic void owe_rsp(rsp_type r);
      bytes_due = {bytes_due, r};
   endfunction

   // mostly legal appends, some finishes, some out-of-range values and lengths
   function automatic req_type random_req();
      int unsigned      pick;
      int unsigned      len;
      logic [31:0]      v;
      req_type          r;
      pick = $urandom_range(99);
      if (pick < 8) begin
         r = make_req(MODE_FINISH, $urandom, LEN_W'($urandom));
      end else if (pick < 13) begin
         len = $urandom_range(31);
         v   = $urandom | (32'd1 << $urandom_range(31, len));
         r   = make_req(MODE_APPEND, v, LEN_W'(len));
      end else if (pick < 16) begin
         r = make_req(MODE_APPEND, $urandom, LEN_W'($urandom_range(63, 33)));
      end else begin
         len = $urandom_range(32);
         v   = $urandom;
         if (len < 32)
            v = v & ((32'd1 << len) - 32'd1);
         r = make_req(MODE_APPEND, v, LEN_W'(len));
      end
      return r;
   endfunction

   // update the shadow packer and queue the results this request owes
   task automatic pack_bits(input req_type rq);
      logic [63:0] acc;
      int unsigned len;
      int unsigned nbits;
      len = rq.bit_len;
      if (rq.mode == MODE_FINISH) begin
         if (fill_cnt != 0)
            owe_rsp(make_rsp(8'({1'b0, part_bits} << (8 - fill_cnt)),
                             KIND_DATA, 1'b1, run_total));
         else
            owe_rsp(make_rsp(8'd0, KIND_NONE, 1'b1, run_total));
         part_bits = '0;
         fill_cnt  = '0;
         run_total = '0;
      end else if (len > 32 || (len < 32 && (rq.value >> len) != 0)) begin
         owe_rsp(make_rsp(8'd0, KIND_RANGE, 1'b1, run_total));
      end else if (len > MAX_TOTAL - {1'b0, run_total}) begin
         owe_rsp(make_rsp(8'd0, KIND_LONG, 1'b1, run_total));
      end else begin
         acc       = ({57'd0, part_bits} << len) | {32'd0, rq.value};
         nbits     = fill_cnt + len;
         run_total = run_total + TOTAL_W'(len);
         if (nbits < 8)
            owe_rsp(make_rsp(8'd0, KIND_NONE, 1'b1, run_total));
         while (nbits >= 8) begin
            owe_rsp(make_rsp(8'(acc >> (nbits - 8)), KIND_DATA,
                             nbits < 16, run_total));
            nbits = nbits - 8;
         end
         fill_cnt  = FILL_W'(nbits);
         part_bits = PART_W'(acc & ((64'd1 << nbits) - 64'd1));
      end
   endtask

   // request driver and result-side stalls
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_taken_cnt == req_sent_cnt) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
            req_sent_cnt++;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on accepted requests, check results, watchdog
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pack_bits(req_data);
            req_taken_cnt++;
         end
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               bad_cnt++;
               $display("%0t: unexpected result byte=%02h kind=%0d last=%0b total=%0d",
                        $time, rsp_data.out_byte, rsp_data.kind,
                        rsp_data.last_of_run, rsp_data.bits_total);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.kind !== want.kind ||
                   rsp_data.last_of_run !== want.last_of_run ||
                   rsp_data.bits_total !== want.bits_total) begin
                  bad_cnt++;
                  $display({"%0t: result mismatch, expected byte=%02h kind=%0d last=%0b",
                            " total=%0d, actual byte=%02h kind=%0d last=%0b total=%0d"},
                           $time, want.out_byte, want.kind, want.last_of_run,
                           want.bits_total, rsp_data.out_byte, rsp_data.kind,
                           rsp_data.last_of_run, rsp_data.bits_total);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int unsigned phase;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: empty appends, full words, padding, range errors, finish cases
      add_req(make_req(MODE_APPEND, 32'h0000_0000, 6'd0));
      add_req(make_req(MODE_FINISH, 32'h0000_0000, 6'd0));
      add_req(make_req(MODE_APPEND, 32'hFFFF_FFFF, 6'd32));
      add_req(make_req(MODE_APPEND, 32'h0000_0000, 6'd32));
      add_req(make_req(MODE_APPEND, 32'h0000_0005, 6'd3));
      add_req(make_req(MODE_FINISH, 32'hFFFF_FFFF, 6'd63));
      add_req(make_req(MODE_APPEND, 32'h0000_007F, 6'd7));
      add_req(make_req(MODE_APPEND, 32'hA5A5_A5A5, 6'd32));
      add_req(make_req(MODE_APPEND, 32'h0000_0001, 6'd1));
      add_req(make_req(MODE_APPEND, 32'h0000_0001, 6'd0));
      add_req(make_req(MODE_APPEND, 32'h8000_0000, 6'd31));
      add_req(make_req(MODE_APPEND, 32'h0000_0020, 6'd5));
      add_req(make_req(MODE_APPEND, 32'h0000_0000, 6'd33));
      add_req(make_req(MODE_APPEND, 32'hFFFF_FFFF, 6'd63));
      add_req(make_req(MODE_APPEND, 32'h7FFF_FFFF, 6'd31));
      add_req(make_req(MODE_APPEND, 32'h0000_0055, 6'd7));
      add_req(make_req(MODE_FINISH, 32'h0000_0000, 6'd0));
      add_req(make_req(MODE_APPEND, 32'h0000_00C3, 6'd8));
      add_req(make_req(MODE_APPEND, 32'h0000_0001, 6'd1));
      add_req(make_req(MODE_FINISH, 32'h1234_5678, 6'd17));

      // random phases: no idling, idle sender, stalling receiver, both
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         repeat (ITEMS_PER_PHASE) add_req(random_req());
         @(negedge clock);
         while (req_backlog.size() != 0 || req_taken_cnt != req_sent_cnt ||
                bytes_due.size() != 0)
            @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (bad_cnt == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
